### hw/rtl/rgsp_pkg.sv
// ----------------------------------------------------------------------------
// rgsp_pkg
// shared types, codes and helpers of the run-length glyph scan line painter
// ----------------------------------------------------------------------------
`default_nettype none

package rgsp_pkg;

   // field widths of the request and result items
   localparam int MODE_W   = 3;
   localparam int LINE_W   = 8;
   localparam int POS_W    = 16;
   localparam int GDIM_W   = 8;
   localparam int RLEN_W   = 7;
   localparam int SPAN_L_W = 8;

   // defaults of the top level parameters
   localparam int LINE_HEIGHT_DEF = 32;
   localparam int QUEUE_DEPTH_DEF = 4;

   // gap between glyphs on the pen
   localparam int GLYPH_GAP = 3;

   // request mode codes
   localparam logic [MODE_W-1:0] MODE_BEGIN  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TEXT   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_HEADER = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RUN    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_END    = 3'd4;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_NONE,
      OP_BEGIN,
      OP_TEXT,
      OP_HEADER,
      OP_RUN,
      OP_END
   } op_type;

   // glyph walk phase
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SEEK,
      PH_PAINT
   } phase_type;

   // one queued command
   typedef struct packed {
      op_type              op;
      logic [LINE_W-1:0]   line_index;
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic [GDIM_W-1:0]   glyph_width;
      logic [GDIM_W-1:0]   glyph_height;
      logic                run_black;
      logic [RLEN_W-1:0]   run_length;
   } cmd_type;

   // head of the command queue as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   // 16-bit add that saturates at the top
   function automatic logic [POS_W-1:0] sat_add16(input logic [POS_W-1:0] a,
                                                 input logic [8:0]       b);
      logic [POS_W:0] s;
      s = {1'b0, a} + {{(POS_W-8){1'b0}}, b};
      return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/rgsp_if.sv
// ----------------------------------------------------------------------------
// rgsp_if
// request and result channels of the glyph scan line painter
// ----------------------------------------------------------------------------
`default_nettype none

// request channel
interface rgsp_req_if import rgsp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [LINE_W-1:0]   line_index;
   logic [POS_W-1:0]    pos_x;
   logic [POS_W-1:0]    pos_y;
   logic [GDIM_W-1:0]   glyph_width;
   logic [GDIM_W-1:0]   glyph_height;
   logic                run_black;
   logic [RLEN_W-1:0]   run_length;

   modport source (output valid, mode, line_index, pos_x, pos_y, glyph_width,
                   glyph_height, run_black, run_length, input ready);
   modport sink   (input valid, mode, line_index, pos_x, pos_y, glyph_width,
                   glyph_height, run_black, run_length, output ready);
endinterface

// result channel
interface rgsp_rsp_if import rgsp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                span_valid;
   logic [POS_W-1:0]    span_start;
   logic [SPAN_L_W-1:0] span_length;
   logic                glyph_done;
   logic                line_changed;
   logic                line_done;

   modport source (output valid, span_valid, span_start, span_length, glyph_done,
                   line_changed, line_done, input ready);
   modport sink   (input valid, span_valid, span_start, span_length, glyph_done,
                   line_changed, line_done, output ready);
endinterface

`default_nettype wire

### hw/rtl/rle_glyph_scanline_painter_unit.sv
// a request transfer is written into the command queue; the back end pops it and registers its result
// throughput: one item per cycle while the result channel is ready; the back end logic is combinational
// the command queue lets the front keep taking transfers while a result waits at the output
// reset: synchronous, active high; empties the queue, clears the walk state and result valid
// ----------------------------------------------------------------------------
// rle_glyph_scanline_painter_unit
// renders black spans of one scan line from run-length coded glyph rows
// ----------------------------------------------------------------------------
`default_nettype none

module rle_glyph_scanline_painter_unit import rgsp_pkg::*; #(
   parameter int LINE_HEIGHT = LINE_HEIGHT_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rgsp_req_if.sink   req_ch,
   rgsp_rsp_if.source rsp_ch
);

   q_head_type head;
   logic       pop;

   // accept and classify
   rgsp_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .head   (head),
      .pop    (pop)
   );

   // execute and report
   rgsp_back #(
      .LINE_HEIGHT (LINE_HEIGHT)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

### hw/rtl/rgsp_front.sv
// ----------------------------------------------------------------------------
// rgsp_front
// accepts request transfers, classifies the mode and queues the commands
// ----------------------------------------------------------------------------
`default_nettype none

module rgsp_front import rgsp_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rgsp_req_if.sink    req_ch,
   output q_head_type  head,
   input  wire logic   pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   op_type           op;
   cmd_type          cmd;

   // classify the incoming mode
   always_comb begin
      case (req_ch.mode)
         MODE_BEGIN:  op = OP_BEGIN;
         MODE_TEXT:   op = OP_TEXT;
         MODE_HEADER: op = OP_HEADER;
         MODE_RUN:    op = OP_RUN;
         MODE_END:    op = OP_END;
         default:     op = OP_NONE;
      endcase
   end

   always_comb begin
      cmd.op           = op;
      cmd.line_index   = req_ch.line_index;
      cmd.pos_x        = req_ch.pos_x;
      cmd.pos_y        = req_ch.pos_y;
      cmd.glyph_width  = req_ch.glyph_width;
      cmd.glyph_height = req_ch.glyph_height;
      cmd.run_black    = req_ch.run_black;
      cmd.run_length   = req_ch.run_length;
   end

   // queue handshake
   assign req_ch.ready = (count_ff != CNT_FULL);
   assign push         = req_ch.valid && req_ch.ready;
   assign head.valid   = (count_ff != '0);
   assign head.cmd     = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cmd;
      end
   end

`ifndef SYNTH
   // fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue fill count beyond depth");

   // back end never pops an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

   // a transfer with no pop grows the fill count by one
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill count lost a transfer");
`endif

endmodule

`default_nettype wire

### hw/rtl/rgsp_back.sv
// ----------------------------------------------------------------------------
// rgsp_back
// carries out queued commands: glyph row seek, span clipping, line marking
// ----------------------------------------------------------------------------
`default_nettype none

module rgsp_back import rgsp_pkg::*; #(
   parameter int LINE_HEIGHT = LINE_HEIGHT_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire q_head_type head,
   output logic            pop,
   rgsp_rsp_if.source      rsp_ch
);

   typedef struct packed {
      logic                span_valid;
      logic [POS_W-1:0]    span_start;
      logic [SPAN_L_W-1:0] span_length;
      logic                glyph_done;
      logic                line_changed;
      logic                line_done;
   } res_type;

   // walk state
   logic [LINE_W-1:0]  current_line_ff, current_line_in;
   logic [POS_W-1:0]   text_top_ff, text_top_in;
   logic [POS_W-1:0]   pen_column_ff, pen_column_in;
   logic [POS_W-1:0]   glyph_column_ff, glyph_column_in;
   logic               text_in_band_ff, text_in_band_in;
   logic               line_stopped_ff, line_stopped_in;
   logic               changed_flag_ff, changed_flag_in;
   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   row_start_ff, row_start_in;
   logic [POS_W-1:0]   run_sum_ff, run_sum_in;
   logic [GDIM_W-1:0]  pixel_ff, pixel_in;
   logic [GDIM_W-1:0]  width_ff, width_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   res_type            out_ff, res_in;

   // datapath helpers
   cmd_type            cmd;
   logic [POS_W:0]     line17;
   logic [POS_W:0]     py17;
   logic [POS_W:0]     band_end;
   logic               margin_hit;
   logic               in_band;
   logic [18:0]        row_w;
   logic [POS_W-1:0]   row_prod;
   logic [POS_W:0]     seek_sum;
   logic [POS_W:0]     paint_len;
   logic               do_paint;
   logic [GDIM_W-1:0]  room;
   logic [GDIM_W-1:0]  paint_n;
   logic               span_hit;

   assign cmd = head.cmd;
   assign pop = head.valid && (!out_valid_ff || rsp_ch.ready);

   // band and margin tests of a text start
   always_comb begin
      line17     = {{(POS_W+1-LINE_W){1'b0}}, current_line_ff};
      py17       = {1'b0, cmd.pos_y};
      band_end   = py17 + (POS_W+1)'(LINE_HEIGHT);
      margin_hit = ((cmd.pos_y != '0) && (line17 == py17 - 1'b1)) ||
                   (line17 == band_end + 1'b1);
      in_band    = (line17 >= py17) && (line17 < band_end);
   end

   // glyph row and row start offset of a header
   always_comb begin
      row_w    = {11'b0, current_line_ff} + {11'b0, cmd.glyph_height}
               - {3'b0, text_top_ff} - 19'(LINE_HEIGHT);
      row_prod = {8'b0, row_w[7:0]} * {8'b0, cmd.glyph_width};
      seek_sum = {1'b0, run_sum_ff} + {{(POS_W+1-RLEN_W){1'b0}}, cmd.run_length};
   end

   // next state
   always_comb begin
      current_line_in = current_line_ff;
      text_top_in     = text_top_ff;
      pen_column_in   = pen_column_ff;
      glyph_column_in = glyph_column_ff;
      text_in_band_in = text_in_band_ff;
      line_stopped_in = line_stopped_ff;
      changed_flag_in = changed_flag_ff;
      phase_in        = phase_ff;
      row_start_in    = row_start_ff;
      run_sum_in      = run_sum_ff;
      pixel_in        = pixel_ff;
      width_in        = width_ff;
      paint_len       = '0;
      do_paint        = 1'b0;
      room            = width_ff - pixel_ff;
      paint_n         = '0;
      span_hit        = 1'b0;

      case (cmd.op)
         OP_BEGIN: begin
            current_line_in = cmd.line_index;
            text_top_in     = '0;
            pen_column_in   = '0;
            glyph_column_in = '0;
            text_in_band_in = 1'b0;
            line_stopped_in = 1'b0;
            changed_flag_in = 1'b0;
            phase_in        = PH_IDLE;
            row_start_in    = '0;
            run_sum_in      = '0;
            pixel_in        = '0;
            width_in        = '0;
         end
         OP_TEXT: begin
            if (!line_stopped_ff) begin
               phase_in      = PH_IDLE;
               text_top_in   = cmd.pos_y;
               pen_column_in = cmd.pos_x;
               if (margin_hit) begin
                  changed_flag_in = 1'b1;
                  line_stopped_in = 1'b1;
                  text_in_band_in = 1'b0;
               end else begin
                  text_in_band_in = in_band;
               end
            end
         end
         OP_HEADER: begin
            phase_in = PH_IDLE;
            if (!line_stopped_ff && text_in_band_ff) begin
               glyph_column_in = pen_column_ff;
               pen_column_in   = sat_add16(pen_column_ff,
                                           {1'b0, cmd.glyph_width} + 9'(GLYPH_GAP));
               if (!row_w[18]) begin
                  changed_flag_in = 1'b1;
                  if (cmd.glyph_width != '0) begin
                     row_start_in = row_prod;
                     run_sum_in   = '0;
                     pixel_in     = '0;
                     width_in     = cmd.glyph_width;
                     phase_in     = PH_SEEK;
                  end
               end
            end
         end
         OP_RUN: begin
            if (!line_stopped_ff && phase_ff != PH_IDLE) begin
               if (cmd.run_length == '0) begin
                  phase_in = PH_IDLE;
               end else if (phase_ff == PH_SEEK) begin
                  run_sum_in = seek_sum[POS_W-1:0];
                  if (seek_sum > {1'b0, row_start_ff}) begin
                     phase_in  = PH_PAINT;
                     paint_len = seek_sum - {1'b0, row_start_ff};
                     do_paint  = 1'b1;
                  end
               end else begin
                  paint_len = {{(POS_W+1-RLEN_W){1'b0}}, cmd.run_length};
                  do_paint  = 1'b1;
               end
            end
         end
         OP_END, OP_NONE: begin
            phase_in = phase_ff;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      // clip the run to the rest of the glyph row
      if (do_paint) begin
         paint_n  = (paint_len < {{(POS_W+1-GDIM_W){1'b0}}, room})
                  ? paint_len[GDIM_W-1:0] : room;
         span_hit = cmd.run_black && (paint_n != '0);
         pixel_in = pixel_ff + paint_n;
         if (pixel_in >= width_ff) begin
            phase_in = PH_IDLE;
         end
      end
   end

   // result fields
   always_comb begin
      res_in.span_valid   = span_hit;
      res_in.span_start   = span_hit ? sat_add16(glyph_column_ff, {1'b0, pixel_ff}) : '0;
      res_in.span_length  = span_hit ? paint_n : '0;
      res_in.glyph_done   = (phase_in == PH_IDLE);
      res_in.line_changed = changed_flag_in;
      res_in.line_done    = (cmd.op == OP_END);
   end

   // result register handshake
   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         current_line_ff <= '0;
         text_top_ff     <= '0;
         pen_column_ff   <= '0;
         glyph_column_ff <= '0;
         text_in_band_ff <= 1'b0;
         line_stopped_ff <= 1'b0;
         changed_flag_ff <= 1'b0;
         phase_ff        <= PH_IDLE;
         row_start_ff    <= '0;
         run_sum_ff      <= '0;
         pixel_ff        <= '0;
         width_ff        <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            current_line_ff <= current_line_in;
            text_top_ff     <= text_top_in;
            pen_column_ff   <= pen_column_in;
            glyph_column_ff <= glyph_column_in;
            text_in_band_ff <= text_in_band_in;
            line_stopped_ff <= line_stopped_in;
            changed_flag_ff <= changed_flag_in;
            phase_ff        <= phase_in;
            row_start_ff    <= row_start_in;
            run_sum_ff      <= run_sum_in;
            pixel_ff        <= pixel_in;
            width_ff        <= width_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= res_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.span_valid   = out_ff.span_valid;
   assign rsp_ch.span_start   = out_ff.span_start;
   assign rsp_ch.span_length  = out_ff.span_length;
   assign rsp_ch.glyph_done   = out_ff.glyph_done;
   assign rsp_ch.line_changed = out_ff.line_changed;
   assign rsp_ch.line_done    = out_ff.line_done;

`ifndef SYNTH
   // a reported span always covers pixels
   a_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.span_valid) |-> out_ff.span_length != '0)
      else $error("span reported with zero length");

   // glyph done in the result matches the phase left behind
   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      pop |=> out_ff.glyph_done == (phase_ff == PH_IDLE))
      else $error("glyph done disagrees with phase");

   // a stopped line never has a text in band
   a_stop_band: assert property (@(posedge clock) disable iff (reset)
      line_stopped_ff |-> !text_in_band_ff)
      else $error("text in band on a stopped line");

   // painting always has pixels left in the row
   a_paint_room: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAINT) |-> pixel_ff < width_ff)
      else $error("painting past the glyph width");
`endif

endmodule

`default_nettype wire

### test/rle_glyph_scanline_painter_unit_tb.sv
// ----------------------------------------------------------------------------
// rle_glyph_scanline_painter_unit_tb
// self-checking bench for the run-length glyph scan line painter: a queued
// driver feeds begin line, text, glyph header, run byte and end commands, an
// in-bench painter model predicts every result and a monitor compares each
// result transfer, under changing sender and receiver idle patterns
// ----------------------------------------------------------------------------
`default_nettype none

module rle_glyph_scanline_painter_unit_tb import rgsp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LH              = LINE_HEIGHT_DEF;
   localparam int CLK_HALF        = 2;
   localparam int RESET_CYCLES    = 10;
   localparam int RANDOM_ITEMS    = 1550;
   localparam int PHASE_ITEMS     = 200;
   localparam int HOLD_AT         = 100;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_CYCLES    = 8;
   localparam int IDLE_LIMIT      = 2000;
   localparam int MAX_REPORTS     = 10;

   // modes with no function
   localparam int MODE_UNUSED_FIRST = 5;
   localparam int MODE_UNUSED_LAST  = 7;

   typedef enum logic [1:0] {
      TRAFFIC_FREE,
      TRAFFIC_SENDER_IDLE,
      TRAFFIC_RECEIVER_STALL,
      TRAFFIC_BOTH
   } traffic_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [LINE_W-1:0] line_index;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [GDIM_W-1:0] glyph_width;
      logic [GDIM_W-1:0] glyph_height;
      logic              run_black;
      logic [RLEN_W-1:0] run_length;
   } glyph_cmd_type;

   typedef struct packed {
      logic                span_valid;
      logic [POS_W-1:0]    span_start;
      logic [SPAN_L_W-1:0] span_length;
      logic                glyph_done;
      logic                line_changed;
      logic                line_done;
   } span_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rgsp_req_if req_ch ();
   rgsp_rsp_if rsp_ch ();

   rle_glyph_scanline_painter_unit #(
      .LINE_HEIGHT(LH)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #(CLK_HALF) clock = ~clock;

   glyph_cmd_type   pending_cmds_q[$];
   span_result_type expected_spans_q[$];
   int              n_queued   = 0;
   int              n_accepted = 0;
   int              n_fail     = 0;
   logic            req_fired  = 1'b0;
   int              hold_left  = 0;
   logic            hold_done  = 1'b0;
   int              quiet_cycles = 0;

   // painter model state
   logic [LINE_W-1:0] pm_line;
   logic [POS_W-1:0]  pm_top;
   logic [POS_W-1:0]  pm_pen;
   logic [POS_W-1:0]  pm_glyph_col;
   logic              pm_in_band;
   logic              pm_stopped;
   logic              pm_changed;
   phase_type         pm_phase;
   logic [POS_W-1:0]  pm_row_offset;
   logic [POS_W-1:0]  pm_run_sum;
   logic [GDIM_W-1:0] pm_pixel;
   logic [GDIM_W-1:0] pm_width;

   // column add clamped at the top of the 16-bit range
   function automatic logic [POS_W-1:0] clamp_column(input int a, input int b);
      int s;
      s = a + b;
      return (s > 65535) ? 16'hFFFF : POS_W'(s);
   endfunction

   function automatic void clear_painter();
      pm_line       = '0;
      pm_top        = '0;
      pm_pen        = '0;
      pm_glyph_col  = '0;
      pm_in_band    = 1'b0;
      pm_stopped    = 1'b0;
      pm_changed    = 1'b0;
      pm_phase      = PH_IDLE;
      pm_row_offset = '0;
      pm_run_sum    = '0;
      pm_pixel      = '0;
      pm_width      = '0;
   endfunction

   // lay a run onto the current glyph row, clipped at the glyph width
   function automatic void lay_run(input int len, input logic black,
                                   inout span_result_type r);
      int room;
      int n;
      room = int'(pm_width) - int'(pm_pixel);
      n    = (len < room) ? len : room;
      if (black && n > 0) begin
         r.span_valid  = 1'b1;
         r.span_start  = clamp_column(int'(pm_glyph_col), int'(pm_pixel));
         r.span_length = n[SPAN_L_W-1:0];
      end
      pm_pixel = pm_pixel + n[GDIM_W-1:0];
      if (pm_pixel >= pm_width) pm_phase = PH_IDLE;
   endfunction

   function automatic span_result_type predict_span(input glyph_cmd_type c);
      span_result_type r;
      int line;
      int py;
      int row;
      int sum;
      r    = '0;
      line = int'(pm_line);
      py   = int'(c.pos_y);
      case (c.mode)
         MODE_BEGIN: begin
            clear_painter();
            pm_line = c.line_index;
         end
         MODE_TEXT: begin
            if (!pm_stopped) begin
               pm_phase = PH_IDLE;
               pm_top   = c.pos_y;
               pm_pen   = c.pos_x;
               // margin line just above the band or the second line below it stops the line
               if ((py > 0 && line == py - 1) || line == py + LH + 1) begin
                  pm_changed = 1'b1;
                  pm_stopped = 1'b1;
                  pm_in_band = 1'b0;
               end else begin
                  pm_in_band = (line >= py) && (line < py + LH);
               end
            end
         end
         MODE_HEADER: begin
            pm_phase = PH_IDLE;
            if (!pm_stopped && pm_in_band) begin
               row = line - int'(pm_top) - (LH - int'(c.glyph_height));
               pm_glyph_col = pm_pen;
               pm_pen = clamp_column(int'(pm_pen), int'(c.glyph_width) + GLYPH_GAP);
               if (row >= 0) begin
                  pm_changed = 1'b1;
                  if (c.glyph_width != '0) begin
                     pm_row_offset = POS_W'((row & 255) * int'(c.glyph_width));
                     pm_run_sum    = '0;
                     pm_pixel      = '0;
                     pm_width      = c.glyph_width;
                     pm_phase      = PH_SEEK;
                  end
               end
            end
         end
         MODE_RUN: begin
            if (!pm_stopped && pm_phase != PH_IDLE) begin
               if (c.run_length == '0) begin
                  pm_phase = PH_IDLE;
               end else if (pm_phase == PH_SEEK) begin
                  sum        = int'(pm_run_sum) + int'(c.run_length);
                  pm_run_sum = POS_W'(sum);
                  if (sum > int'(pm_row_offset)) begin
                     pm_phase = PH_PAINT;
                     lay_run(sum - int'(pm_row_offset), c.run_black, r);
                  end
               end else begin
                  lay_run(int'(c.run_length), c.run_black, r);
               end
            end
         end
         default: ;
      endcase
      r.glyph_done   = (pm_phase == PH_IDLE);
      r.line_changed = pm_changed;
      r.line_done    = (c.mode == MODE_END);
      return r;
   endfunction

   // command with random filler in the fields its mode does not use
   task automatic queue_cmd(input int mode, input int a, input int b);
      glyph_cmd_type c;
      c.mode         = MODE_W'(mode);
      c.line_index   = LINE_W'($urandom);
      c.pos_x        = POS_W'($urandom);
      c.pos_y        = POS_W'($urandom);
      c.glyph_width  = GDIM_W'($urandom);
      c.glyph_height = GDIM_W'($urandom);
      c.run_black    = 1'($urandom);
      c.run_length   = RLEN_W'($urandom);
      case (c.mode)
         MODE_BEGIN: c.line_index = LINE_W'(a);
         MODE_TEXT: begin
            c.pos_x = POS_W'(a);
            c.pos_y = POS_W'(b);
         end
         MODE_HEADER: begin
            c.glyph_width  = GDIM_W'(a);
            c.glyph_height = GDIM_W'(b);
         end
         MODE_RUN: begin
            c.run_black  = 1'(a);
            c.run_length = RLEN_W'(b);
         end
         default: ;
      endcase
      pending_cmds_q.push_back(c);
      n_queued++;
   endtask

   task automatic note_failure(input string msg);
      n_fail++;
      if (n_fail <= MAX_REPORTS) $display("%0t ns: %s", $realtime, msg);
   endtask

   function automatic traffic_type current_traffic();
      return traffic_type'((n_accepted / PHASE_ITEMS) % 4);
   endfunction

   // stimulus and end of run
   initial begin
      int line, py, px, d, kind, gw, gh, row, need, total, limit, len;
      logic cut;
      clear_painter();
      req_ch.valid        = 1'b0;
      req_ch.mode         = '0;
      req_ch.line_index   = '0;
      req_ch.pos_x        = '0;
      req_ch.pos_y        = '0;
      req_ch.glyph_width  = '0;
      req_ch.glyph_height = '0;
      req_ch.run_black    = 1'b0;
      req_ch.run_length   = '0;
      rsp_ch.ready        = 1'b0;

      // text out of reach, ignored header, stray run byte, unused modes
      queue_cmd(MODE_BEGIN, 255, 0);
      queue_cmd(MODE_TEXT, 65535, 65535);
      queue_cmd(MODE_HEADER, 255, 255);
      queue_cmd(MODE_RUN, 1, 127);
      for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++) queue_cmd(m, 0, 0);
      queue_cmd(MODE_END, 0, 0);
      // glyphs at the right edge: clipping, column clamp, zero width,
      // header above the first row and a zero run byte while seeking
      queue_cmd(MODE_BEGIN, 40, 0);
      queue_cmd(MODE_TEXT, 65530, 10);
      queue_cmd(MODE_HEADER, 4, 2);
      queue_cmd(MODE_RUN, 1, 127);
      queue_cmd(MODE_HEADER, 5, 32);
      queue_cmd(MODE_RUN, 0, 127);
      queue_cmd(MODE_RUN, 1, 30);
      queue_cmd(MODE_HEADER, 0, 40);
      queue_cmd(MODE_HEADER, 3, 1);
      queue_cmd(MODE_HEADER, 2, 31);
      queue_cmd(MODE_RUN, 1, 0);
      queue_cmd(MODE_END, 0, 0);
      // margin line above, then below a text band
      queue_cmd(MODE_BEGIN, 9, 0);
      queue_cmd(MODE_TEXT, 0, 10);
      queue_cmd(MODE_HEADER, 4, 32);
      queue_cmd(MODE_BEGIN, 43, 0);
      queue_cmd(MODE_TEXT, 0, 10);
      queue_cmd(MODE_END, 0, 0);

      // random lines, mostly well formed with a little noise
      limit = n_queued + RANDOM_ITEMS;
      while (n_queued < limit) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6))
               queue_cmd($urandom_range(0, 7), $urandom, $urandom);
         end else begin
            line = $urandom_range(0, 255);
            queue_cmd(MODE_BEGIN, line, 0);
            repeat ($urandom_range(1, 3)) begin
               // text placement: in band, margin above, margin below, anywhere
               kind = $urandom_range(0, 9);
               if (kind < 7) begin
                  d  = $urandom_range(0, (line < LH - 1) ? line : LH - 1);
                  py = line - d;
               end else if (kind == 7) begin
                  py = line + 1;
               end else if (kind == 8 && line >= LH + 1) begin
                  py = line - LH - 1;
               end else begin
                  py = $urandom_range(0, 65535);
               end
               case ($urandom_range(0, 9))
                  0:       px = $urandom_range(65000, 65535);
                  1:       px = $urandom_range(0, 65535);
                  default: px = $urandom_range(0, 1000);
               endcase
               queue_cmd(MODE_TEXT, px, py);
               d = line - py;
               repeat ($urandom_range(1, 4)) begin
                  kind = $urandom_range(0, 19);
                  if (kind == 0) gw = 0;
                  else if (kind == 1) gw = $urandom_range(64, 255);
                  else gw = $urandom_range(1, 12);
                  // wide glyphs keep to their first rows, a few start below the line
                  row = (kind == 1) ? $urandom_range(0, 1) : $urandom_range(0, 9) - 2;
                  gh  = LH - d + row;
                  if (gh < 0 || gh > 255) gh = $urandom_range(0, 255);
                  queue_cmd(MODE_HEADER, gw, gh);
                  if (row >= 0 && gw > 0) begin
                     // run stream past the end of the target row, sometimes cut short
                     need  = (row + 1) * gw + $urandom_range(0, gw);
                     total = 0;
                     cut   = ($urandom_range(0, 9) == 0);
                     while (total < need && !(cut && $urandom_range(0, 3) == 0)) begin
                        case ($urandom_range(0, 9))
                           0:       len = 127;
                           1:       len = $urandom_range(1, 127);
                           default: len = $urandom_range(1, (gw * 2 < 127) ? gw * 2 : 127);
                        endcase
                        queue_cmd(MODE_RUN, $urandom_range(0, 1), len);
                        total += len;
                     end
                     if ($urandom_range(0, 3) != 0) queue_cmd(MODE_RUN, $urandom_range(0, 1), 0);
                  end else begin
                     repeat ($urandom_range(0, 2))
                        queue_cmd(MODE_RUN, $urandom_range(0, 1), $urandom_range(0, 127));
                  end
               end
            end
            if ($urandom_range(0, 9) != 0) queue_cmd(MODE_END, 0, 0);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      wait (n_accepted == n_queued && expected_spans_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_spans_q.size() != 0)
         note_failure($sformatf("%0d expected results never arrived", expected_spans_q.size()));
      if (n_fail == 0) begin
         $display("rle_glyph_scanline_painter_unit_tb: PASS");
      end else begin
         $display("rle_glyph_scanline_painter_unit_tb: FAIL");
      end
      $finish;
   end

   // request driver
   always @(negedge clock) begin : drive_req
      glyph_cmd_type c;
      traffic_type   t;
      logic          idle;
      t    = current_traffic();
      idle = (t == TRAFFIC_SENDER_IDLE && $urandom_range(0, 99) < 67) ||
             (t == TRAFFIC_BOTH && $urandom_range(0, 99) < 25);
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fired) begin
         if (pending_cmds_q.size() != 0 && !idle) begin
            c = pending_cmds_q.pop_front();
            req_ch.valid        <= 1'b1;
            req_ch.mode         <= c.mode;
            req_ch.line_index   <= c.line_index;
            req_ch.pos_x        <= c.pos_x;
            req_ch.pos_y        <= c.pos_y;
            req_ch.glyph_width  <= c.glyph_width;
            req_ch.glyph_height <= c.glyph_height;
            req_ch.run_black    <= c.run_black;
            req_ch.run_length   <= c.run_length;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result ready, with one long hold-off so the command queue fills up
   always @(negedge clock) begin : drive_ready
      traffic_type t;
      logic        stall;
      t     = current_traffic();
      stall = (t == TRAFFIC_RECEIVER_STALL && $urandom_range(0, 99) < 67) ||
              (t == TRAFFIC_BOTH && $urandom_range(0, 99) < 25);
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= HOLD_OFF_CYCLES;
         hold_done    <= 1'b1;
      end else begin
         rsp_ch.ready <= !stall;
      end
   end

   // monitor: predict on request transfers, check on result transfers
   always @(posedge clock) begin : monitor
      glyph_cmd_type   c;
      span_result_type got;
      span_result_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            c.mode         = req_ch.mode;
            c.line_index   = req_ch.line_index;
            c.pos_x        = req_ch.pos_x;
            c.pos_y        = req_ch.pos_y;
            c.glyph_width  = req_ch.glyph_width;
            c.glyph_height = req_ch.glyph_height;
            c.run_black    = req_ch.run_black;
            c.run_length   = req_ch.run_length;
            expected_spans_q.push_back(predict_span(c));
            n_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.span_valid   = rsp_ch.span_valid;
            got.span_start   = rsp_ch.span_start;
            got.span_length  = rsp_ch.span_length;
            got.glyph_done   = rsp_ch.glyph_done;
            got.line_changed = rsp_ch.line_changed;
            got.line_done    = rsp_ch.line_done;
            if (expected_spans_q.size() == 0) begin
               note_failure("result transfer with no result expected");
            end else begin
               want = expected_spans_q.pop_front();
               if (got.span_valid !== want.span_valid || got.span_start !== want.span_start ||
                   got.span_length !== want.span_length || got.glyph_done !== want.glyph_done ||
                   got.line_changed !== want.line_changed || got.line_done !== want.line_done)
                  note_failure($sformatf(
                     "mismatch: span v/start/len %0b/%0d/%0d done %0b chg %0b end %0b, expected %0b/%0d/%0d done %0b chg %0b end %0b",
                     got.span_valid, got.span_start, got.span_length, got.glyph_done,
                     got.line_changed, got.line_done, want.span_valid, want.span_start,
                     want.span_length, want.glyph_done, want.line_changed, want.line_done));
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("rle_glyph_scanline_painter_unit_tb: FAIL");
         $finish;
      end
   end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/rgsp_pkg.sv
hw/rtl/rgsp_if.sv
hw/rtl/rgsp_front.sv
hw/rtl/rgsp_back.sv
hw/rtl/rle_glyph_scanline_painter_unit.sv
test/rle_glyph_scanline_painter_unit_tb.sv
